>>> hdl/subtitle_description_packet_parser_defines.svh
// Assertion macros shared by the subtitle description packet parser RTL.
`ifndef SUBTITLE_DESCRIPTION_PACKET_PARSER_DEFINES_SVH
`define SUBTITLE_DESCRIPTION_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SDPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define SDPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sdpp_pkg.sv
// Package with item types, record kind codes and constants of the packet parser.
`timescale 1ns / 1ps

package sdpp_pkg;

  localparam int DESCRIPTOR_COUNT_DEFAULT = 5;
  localparam int BLOCK_BYTES_DEFAULT      = 45;

  localparam logic [7:0] ID_FIRST   = 8'h51;
  localparam logic [7:0] ID_SECOND  = 8'h15;
  localparam logic [7:0] LINE_MASK  = 8'h1f;
  localparam logic [7:0] FIELD_MASK = 8'h80;

  localparam logic [2:0] KIND_HEADER     = 3'd0;
  localparam logic [2:0] KIND_DESCRIPTOR = 3'd1;
  localparam logic [2:0] KIND_DATA       = 3'd2;
  localparam logic [2:0] KIND_TRAILER    = 3'd3;
  localparam logic [2:0] KIND_ID_ERROR   = 3'd4;

  localparam int BLOCK_COUNT_W = 3;
  localparam int LIST_DEPTH    = 2 ** BLOCK_COUNT_W;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  format_byte;
    logic [7:0]  declared_length;
    logic [2:0]  descriptor_index;
    logic [4:0]  line_number;
    logic        field_bit;
    logic        present;
    logic [5:0]  data_offset;
    logic [7:0]  data_value;
    logic [15:0] sequence_count;
    logic [7:0]  checksum_byte;
    logic        checksum_ok;
  } out_item_t;

endpackage

>>> hdl/sdpp_stream_if.sv
// Valid/ready stream interface carrying one item per handshake.
`timescale 1ns / 1ps

interface sdpp_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/subtitle_description_packet_parser.sv
// Subtitle description packet parser: one payload byte in, at most one record out.
// Records are registered in the output register, or in the skid entry on a stall.
// Throughput: one byte per cycle while the skid is empty; single registered decode.
// A two-entry output buffer keeps input ready while one record waits downstream.
// Reset (rst, synchronous) clears packet state and empties the output buffer.
`timescale 1ns / 1ps
`include "subtitle_description_packet_parser_defines.svh"

module subtitle_description_packet_parser #(
  parameter int DESCRIPTOR_COUNT = sdpp_pkg::DESCRIPTOR_COUNT_DEFAULT,
  parameter int BLOCK_BYTES      = sdpp_pkg::BLOCK_BYTES_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  sdpp_stream_if.sink   byte_chan,
  sdpp_stream_if.source record_chan
);

  localparam int DATA_START = 4 + DESCRIPTOR_COUNT;
  localparam int SEQ_RAW_W  =
    $clog2(DATA_START + BLOCK_BYTES * (sdpp_pkg::LIST_DEPTH - 1) + 3);
  localparam int SEQ_W      = (SEQ_RAW_W > 9) ? SEQ_RAW_W : 9;
  localparam int BW         = sdpp_pkg::BLOCK_COUNT_W;

  logic [7:0]    byte_position, byte_position_next;
  logic [7:0]    length_reg, length_reg_next;
  logic          first_id_ok, first_id_ok_next;
  logic          id_failed, id_failed_next;
  logic [BW-1:0] block_count, block_count_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [15:0]   sequence_reg, sequence_reg_next;
  logic [7:0]    checksum_reg, checksum_reg_next;
  logic [5:0]    offset_count, offset_count_next;
  logic [BW-1:0] block_index, block_index_next;
  logic [2:0]    present_list [sdpp_pkg::LIST_DEPTH];

  logic                accept;
  logic [7:0]          b;
  logic                last;
  logic [SEQ_W-1:0]    seq_at;
  logic [SEQ_W-1:0]    pos_ext;
  logic                produce;
  logic                clear;
  logic                list_write;
  logic [2:0]          desc_index;
  sdpp_pkg::out_item_t rec;

  logic                out_valid;
  sdpp_pkg::out_item_t out_data;
  logic                skid_valid;
  sdpp_pkg::out_item_t skid_data;

  assign accept = byte_chan.valid && byte_chan.ready;
  assign b      = byte_chan.payload.byte_value;
  assign last   = byte_chan.payload.last_byte;

  assign seq_at  = SEQ_W'(DATA_START) + SEQ_W'(BLOCK_BYTES) * SEQ_W'(block_count);
  assign pos_ext = SEQ_W'(byte_position);
  assign desc_index = 3'(byte_position - 8'd4);

  always_comb begin
    byte_position_next = byte_position;
    length_reg_next    = length_reg;
    first_id_ok_next   = first_id_ok;
    id_failed_next     = id_failed;
    block_count_next   = block_count;
    running_sum_next   = running_sum;
    sequence_reg_next  = sequence_reg;
    checksum_reg_next  = checksum_reg;
    offset_count_next  = offset_count;
    block_index_next   = block_index;
    produce            = 1'b0;
    clear              = 1'b0;
    list_write         = 1'b0;
    rec                = '0;

    if (accept) begin
      if (id_failed) begin
        clear = last;
      end else begin
        running_sum_next = running_sum + b;
        if (byte_position == 8'd0) begin
          first_id_ok_next = (b == sdpp_pkg::ID_FIRST);
        end
        if (byte_position == 8'd0 && last) begin
          produce         = 1'b1;
          rec.record_kind = sdpp_pkg::KIND_ID_ERROR;
          clear           = 1'b1;
        end else if (byte_position == 8'd1 &&
                     (!first_id_ok || b != sdpp_pkg::ID_SECOND)) begin
          produce         = 1'b1;
          rec.record_kind = sdpp_pkg::KIND_ID_ERROR;
          id_failed_next  = 1'b1;
          clear           = last;
        end else begin
          if (byte_position == 8'd2) begin
            length_reg_next = b;
          end
          if (byte_position != 8'hff) begin
            if (pos_ext == seq_at + SEQ_W'(1)) begin
              sequence_reg_next[15:8] = b;
            end
            if (pos_ext == seq_at + SEQ_W'(2)) begin
              sequence_reg_next[7:0] = b;
            end
            if (byte_position >= 8'd3 &&
                {1'b0, byte_position} + 9'd1 == {1'b0, length_reg}) begin
              checksum_reg_next = b;
            end
          end
          if (last) begin
            produce            = 1'b1;
            rec.record_kind    = sdpp_pkg::KIND_TRAILER;
            rec.sequence_count = sequence_reg_next;
            rec.checksum_byte  = checksum_reg_next;
            rec.checksum_ok    = (running_sum_next == 8'd0);
            clear              = 1'b1;
          end else if (byte_position != 8'hff) begin
            byte_position_next = byte_position + 8'd1;
            if (byte_position == 8'd3) begin
              produce             = 1'b1;
              rec.record_kind     = sdpp_pkg::KIND_HEADER;
              rec.format_byte     = b;
              rec.declared_length = length_reg;
            end else if (byte_position >= 8'd4 && byte_position < 8'(DATA_START)) begin
              if ({1'b0, byte_position} + 9'd4 < {1'b0, length_reg}) begin
                produce              = 1'b1;
                rec.record_kind      = sdpp_pkg::KIND_DESCRIPTOR;
                rec.descriptor_index = desc_index;
                rec.line_number      = 5'(b & sdpp_pkg::LINE_MASK);
                rec.field_bit        = |(b & sdpp_pkg::FIELD_MASK);
                rec.present          = (b != 8'd0);
                if (b != 8'd0) begin
                  list_write       = 1'b1;
                  block_count_next = block_count + BW'(1);
                end
              end
            end else if (byte_position >= 8'(DATA_START) && pos_ext < seq_at) begin
              produce              = 1'b1;
              rec.record_kind      = sdpp_pkg::KIND_DATA;
              rec.descriptor_index = present_list[block_index];
              rec.data_offset      = offset_count;
              rec.data_value       = b;
            end
            if (byte_position >= 8'(DATA_START)) begin
              if (offset_count == 6'(BLOCK_BYTES - 1)) begin
                offset_count_next = 6'd0;
                block_index_next  = block_index + BW'(1);
              end else begin
                offset_count_next = offset_count + 6'd1;
              end
            end
          end
        end
      end
    end

    if (clear) begin
      byte_position_next = '0;
      length_reg_next    = '0;
      first_id_ok_next   = 1'b0;
      id_failed_next     = 1'b0;
      block_count_next   = '0;
      running_sum_next   = '0;
      sequence_reg_next  = '0;
      checksum_reg_next  = '0;
      offset_count_next  = '0;
      block_index_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      length_reg    <= '0;
      first_id_ok   <= 1'b0;
      id_failed     <= 1'b0;
      block_count   <= '0;
      running_sum   <= '0;
      sequence_reg  <= '0;
      checksum_reg  <= '0;
      offset_count  <= '0;
      block_index   <= '0;
    end else begin
      byte_position <= byte_position_next;
      length_reg    <= length_reg_next;
      first_id_ok   <= first_id_ok_next;
      id_failed     <= id_failed_next;
      block_count   <= block_count_next;
      running_sum   <= running_sum_next;
      sequence_reg  <= sequence_reg_next;
      checksum_reg  <= checksum_reg_next;
      offset_count  <= offset_count_next;
      block_index   <= block_index_next;
    end
  end

  // Each present descriptor's number, in the order the data blocks follow.
  always_ff @(posedge clk) begin
    if (list_write) begin
      present_list[block_count] <= desc_index;
    end
  end

  assign byte_chan.ready     = !skid_valid;
  assign record_chan.valid   = out_valid;
  assign record_chan.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (record_chan.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (record_chan.ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (produce) begin
        out_data <= rec;
      end
    end else if (produce) begin
      skid_data <= rec;
    end
  end

  `SDPP_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "Skid entry held while the output register is empty.")
  `SDPP_ASSERT_NOW(a_failed_silent, accept && id_failed, !produce,
    "Record produced after an identifier failure.")
  `SDPP_ASSERT_NOW(a_block_count_bound, 1'b1, block_count <= BW'(DESCRIPTOR_COUNT),
    "More data blocks than descriptors.")
  `SDPP_ASSERT_NOW(a_data_offset_bound,
    out_valid && out_data.record_kind == sdpp_pkg::KIND_DATA,
    out_data.data_offset < 6'(BLOCK_BYTES),
    "Data offset beyond the block.")
  `SDPP_ASSERT_NEXT(a_clear_after_last, accept && last,
    byte_position == 8'd0 && block_count == '0 && !id_failed,
    "Packet state not cleared after the final byte.")

endmodule
